// ===== design/r3e_pkg.sv =====
// ----------------------------------------------------------------------------
// r3e_pkg
// Shared types, constants and small tables for the RFC3339 text to epoch
// nanoseconds converter.
// ----------------------------------------------------------------------------
package r3e_pkg;

  // Fraction digits kept; further digits are skipped.
  localparam int FRACTION_DIGITS = 9;
  localparam logic [3:0] FRAC_FULL_DIGITS = 4'd9;

  localparam logic [13:0] YEAR_MIN = 14'd1970;

  // ASCII characters that the parser looks for.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;

  // floor(x / 25) == (x * RECIP25) >> RECIP_SHIFT for x below 2500.
  localparam logic [29:0] RECIP25     = 30'd5243;
  localparam int          RECIP_SHIFT = 17;

  localparam logic [29:0] DAYS_PER_YEAR = 30'd365;
  localparam logic [29:0] UNIT_FACTOR   = 30'd1;
  localparam logic [29:0] SECS_PER_DAY  = 30'd86400;
  localparam logic [29:0] SECS_PER_HOUR = 30'd3600;
  localparam logic [29:0] SECS_PER_MIN  = 30'd60;
  localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;

  // Day number of 1970-01-01 in the March-based count, plus one for the
  // one-based day of month.
  localparam logic signed [31:0] DAYS_BEFORE_EPOCH = 32'sd719469;

  localparam logic signed [63:0] SECS_LIMIT    = 64'sd9223372036;
  localparam logic signed [63:0] NS_TAIL_LIMIT = 64'sd854775807;

  // Seconds are split into a low part of this many bits and a signed high
  // part for the final scaling to nanoseconds.
  localparam int SPLIT_SHIFT = 17;

  typedef enum logic [2:0] {
    PH_FIXED,
    PH_AFTER,
    PH_FRAC,
    PH_OFFSET,
    PH_TAIL
  } phase_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_ACC,
    FS_CHECK,
    FS_DONE
  } fin_state_t;

  typedef enum logic [3:0] {
    ST_Q100,
    ST_Q400,
    ST_YEAR,
    ST_Y4,
    ST_Y100,
    ST_Y400,
    ST_MDAY,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_OFFH,
    ST_OFFM,
    ST_FRAC,
    ST_SLO,
    ST_SHI
  } step_t;

  // Parsed fields of one timestamp, as handed to the conversion sequencer.
  typedef struct packed {
    logic        bad;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [29:0] frac;
    logic [3:0]  frac_cnt;
    logic        off_neg;
    logic [4:0]  off_hours;
    logic [5:0]  off_minutes;
  } fields_t;

  // One operation of the shared multiply-accumulate unit.
  typedef struct packed {
    logic        mul_go;
    logic        acc_go;
    logic        load;
    logic        shift_hi;
    logic [31:0] a;
    logic [29:0] b;
  } mac_op_t;

  typedef struct packed {
    logic        busy;
    logic        valid;
    logic        fail;
    logic [63:0] ns;
  } res_t;

  function automatic logic [6:0] two_digit(input logic [3:0] tens, input logic [3:0] ones);
    logic [6:0] t;
    t = {3'b000, tens};
    return (t << 3) + (t << 1) + {3'b000, ones};
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd2:                    r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

  // Days from March 1 to the first of the month, in a March-based year.
  function automatic logic [8:0] march_day(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] r;
    case (n)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd1;
    endcase
    return r;
  endfunction

endpackage

// ===== design/r3e_parser.sv =====
// ----------------------------------------------------------------------------
// r3e_parser
// Character-level parser: one text character per beat, field checks on the
// fly, and the parsed fields of the final character handed out unregistered.
// ----------------------------------------------------------------------------
module r3e_parser import r3e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output fields_t    fld
);

  localparam logic [4:0] P_DASH_MONTH = 5'd4;
  localparam logic [4:0] P_MONTH_HI   = 5'd5;
  localparam logic [4:0] P_MONTH_LO   = 5'd6;
  localparam logic [4:0] P_DASH_DAY   = 5'd7;
  localparam logic [4:0] P_DAY_HI     = 5'd8;
  localparam logic [4:0] P_DAY_LO     = 5'd9;
  localparam logic [4:0] P_T          = 5'd10;
  localparam logic [4:0] P_HOUR_HI    = 5'd11;
  localparam logic [4:0] P_HOUR_LO    = 5'd12;
  localparam logic [4:0] P_COLON_MIN  = 5'd13;
  localparam logic [4:0] P_MIN_HI     = 5'd14;
  localparam logic [4:0] P_MIN_LO     = 5'd15;
  localparam logic [4:0] P_COLON_SEC  = 5'd16;
  localparam logic [4:0] P_SEC_HI     = 5'd17;
  localparam logic [4:0] P_SEC_LO     = 5'd18;

  localparam logic [4:0] P_OFF_HOUR_HI = 5'd0;
  localparam logic [4:0] P_OFF_HOUR_LO = 5'd1;
  localparam logic [4:0] P_OFF_COLON   = 5'd2;
  localparam logic [4:0] P_OFF_MIN_HI  = 5'd3;
  localparam logic [4:0] P_OFF_MIN_LO  = 5'd4;

  localparam logic [6:0] MONTH_MAX  = 7'd12;
  localparam logic [6:0] HOUR_MAX   = 7'd23;
  localparam logic [6:0] MINUTE_MAX = 7'd59;
  localparam logic [6:0] SECOND_MAX = 7'd60;

  logic [4:0]  pos, pos_next;
  phase_t      phase, phase_next;
  logic [13:0] year, year_next;
  logic [3:0]  ydig [4];
  logic [3:0]  ydig_next [4];
  logic [3:0]  month, month_next;
  logic [4:0]  day, day_next;
  logic [4:0]  hour, hour_next;
  logic [5:0]  minute, minute_next;
  logic [5:0]  second, second_next;
  logic [29:0] frac, frac_next;
  logic [3:0]  frac_cnt, frac_cnt_next;
  logic        off_neg, off_neg_next;
  logic [4:0]  off_hours, off_hours_next;
  logic [5:0]  off_minutes, off_minutes_next;
  logic        err, err_next;

  logic        is_dig;
  logic [3:0]  dig;
  logic [6:0]  pair;
  logic [4:0]  dim;
  logic [1:0]  lo_mod;
  logic [1:0]  hi_mod;
  logic        leap;
  logic [17:0] year_wide;
  logic [33:0] frac_wide;

  always_comb begin
    pos_next         = pos;
    phase_next       = phase;
    year_next        = year;
    ydig_next        = ydig;
    month_next       = month;
    day_next         = day;
    hour_next        = hour;
    minute_next      = minute;
    second_next      = second;
    frac_next        = frac;
    frac_cnt_next    = frac_cnt;
    off_neg_next     = off_neg;
    off_hours_next   = off_hours;
    off_minutes_next = off_minutes;
    err_next         = err;

    is_dig = text_byte inside {[CH_ZERO:CH_NINE]};
    dig    = text_byte[3:0];
    pair   = 7'd0;

    // Gregorian leap year from the four year digits: the last two digits
    // decide, unless they are both zero, and then the century digits do.
    lo_mod = {ydig[2][0], 1'b0} + ydig[3][1:0];
    hi_mod = {ydig[0][0], 1'b0} + ydig[1][1:0];
    if (ydig[2] == 4'd0 && ydig[3] == 4'd0) begin
      leap = (hi_mod == 2'd0);
    end else begin
      leap = (lo_mod == 2'd0);
    end
    dim = (month == 4'd2 && leap) ? 5'd29 : month_days(month);

    year_wide = ({4'b0, year} << 3) + ({4'b0, year} << 1) + {14'b0, dig};
    frac_wide = ({4'b0, frac} << 3) + ({4'b0, frac} << 1) + {30'b0, dig};

    if (accept && !err) begin
      case (phase)
        PH_FIXED: begin
          case (pos)
            P_DASH_MONTH, P_DASH_DAY: begin
              if (text_byte != CH_DASH) err_next = 1'b1;
            end
            P_T: begin
              if (text_byte != CH_T) err_next = 1'b1;
            end
            P_COLON_MIN, P_COLON_SEC: begin
              if (text_byte != CH_COLON) err_next = 1'b1;
            end
            default: begin
              if (!is_dig) begin
                err_next = 1'b1;
              end else begin
                case (pos)
                  P_MONTH_HI: month_next = dig;
                  P_MONTH_LO: begin
                    pair = two_digit(month, dig);
                    if (year < YEAR_MIN || pair == 7'd0 || pair > MONTH_MAX) err_next = 1'b1;
                    else month_next = pair[3:0];
                  end
                  P_DAY_HI: day_next = {1'b0, dig};
                  P_DAY_LO: begin
                    pair = two_digit(day[3:0], dig);
                    if (pair == 7'd0 || pair > {2'b00, dim}) err_next = 1'b1;
                    else day_next = pair[4:0];
                  end
                  P_HOUR_HI: hour_next = {1'b0, dig};
                  P_HOUR_LO: begin
                    pair = two_digit(hour[3:0], dig);
                    if (pair > HOUR_MAX) err_next = 1'b1;
                    else hour_next = pair[4:0];
                  end
                  P_MIN_HI: minute_next = {2'b00, dig};
                  P_MIN_LO: begin
                    pair = two_digit(minute[3:0], dig);
                    if (pair > MINUTE_MAX) err_next = 1'b1;
                    else minute_next = pair[5:0];
                  end
                  P_SEC_HI: second_next = {2'b00, dig};
                  P_SEC_LO: begin
                    pair = two_digit(second[3:0], dig);
                    if (pair > SECOND_MAX) err_next = 1'b1;
                    else second_next = pair[5:0];
                  end
                  default: begin
                    year_next = year_wide[13:0];
                    ydig_next[pos[1:0]] = dig;
                  end
                endcase
              end
            end
          endcase
          if (pos >= P_SEC_LO) phase_next = PH_AFTER;
          else pos_next = pos + 5'd1;
        end

        PH_AFTER, PH_FRAC: begin
          if (phase == PH_FRAC && is_dig) begin
            if (frac_cnt < 4'(FRACTION_DIGITS)) begin
              frac_next     = frac_wide[29:0];
              frac_cnt_next = frac_cnt + 4'd1;
            end
          end else if (text_byte == CH_DOT && phase == PH_AFTER) begin
            phase_next = PH_FRAC;
          end else if (text_byte == CH_PLUS || text_byte == CH_DASH) begin
            off_neg_next = (text_byte == CH_DASH);
            phase_next   = PH_OFFSET;
            pos_next     = 5'd0;
          end else begin
            phase_next = PH_TAIL;
          end
        end

        PH_OFFSET: begin
          if (pos == P_OFF_COLON) begin
            if (text_byte != CH_COLON) err_next = 1'b1;
          end else if (!is_dig) begin
            err_next = 1'b1;
          end else begin
            case (pos)
              P_OFF_HOUR_HI: off_hours_next = {1'b0, dig};
              P_OFF_HOUR_LO: begin
                pair = two_digit(off_hours[3:0], dig);
                if (pair > HOUR_MAX) err_next = 1'b1;
                else off_hours_next = pair[4:0];
              end
              P_OFF_MIN_HI: off_minutes_next = {2'b00, dig};
              default: begin
                pair = two_digit(off_minutes[3:0], dig);
                if (pair > MINUTE_MAX) err_next = 1'b1;
                else off_minutes_next = pair[5:0];
              end
            endcase
          end
          if (pos >= P_OFF_MIN_LO) phase_next = PH_TAIL;
          else pos_next = pos + 5'd1;
        end

        default: ;
      endcase
    end

    fld.bad         = err_next || phase_next == PH_FIXED || phase_next == PH_OFFSET;
    fld.year        = year_next;
    fld.month       = month_next;
    fld.day         = day_next;
    fld.hour        = hour_next;
    fld.minute      = minute_next;
    fld.second      = second_next;
    fld.frac        = frac_next;
    fld.frac_cnt    = frac_cnt_next;
    fld.off_neg     = off_neg_next;
    fld.off_hours   = off_hours_next;
    fld.off_minutes = off_minutes_next;
  end

  // The final character hands its fields on and leaves the parser cleared.
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_text)) begin
      pos         <= 5'd0;
      phase       <= PH_FIXED;
      year        <= 14'd0;
      ydig        <= '{default: 4'd0};
      month       <= 4'd0;
      day         <= 5'd0;
      hour        <= 5'd0;
      minute      <= 6'd0;
      second      <= 6'd0;
      frac        <= 30'd0;
      frac_cnt    <= 4'd0;
      off_neg     <= 1'b0;
      off_hours   <= 5'd0;
      off_minutes <= 6'd0;
      err         <= 1'b0;
    end else begin
      pos         <= pos_next;
      phase       <= phase_next;
      year        <= year_next;
      ydig        <= ydig_next;
      month       <= month_next;
      day         <= day_next;
      hour        <= hour_next;
      minute      <= minute_next;
      second      <= second_next;
      frac        <= frac_next;
      frac_cnt    <= frac_cnt_next;
      off_neg     <= off_neg_next;
      off_hours   <= off_hours_next;
      off_minutes <= off_minutes_next;
      err         <= err_next;
    end
  end

endmodule

// ===== design/r3e_mac.sv =====
// ----------------------------------------------------------------------------
// r3e_mac
// Shared multiply-accumulate unit: a registered 32 x 30 bit signed product,
// then a 64-bit add into the accumulator, optionally shifted up.
// ----------------------------------------------------------------------------
module r3e_mac import r3e_pkg::*; (
  input  logic               clk,
  input  mac_op_t            op,
  output logic signed [62:0] prod,
  output logic signed [63:0] acc
);

  logic signed [62:0] a_ext;
  logic signed [62:0] b_ext;
  logic signed [62:0] prod_next;
  logic signed [63:0] addend;
  logic signed [63:0] prod_ext;

  always_comb begin
    a_ext     = $signed({{31{op.a[31]}}, op.a});
    b_ext     = $signed({33'b0, op.b});
    prod_next = a_ext * b_ext;
    prod_ext  = $signed({prod[62], prod});
    addend    = op.shift_hi ? (prod_ext <<< SPLIT_SHIFT) : prod_ext;
  end

  always_ff @(posedge clk) begin
    if (op.mul_go) begin
      prod <= prod_next;
    end
    if (op.acc_go) begin
      acc <= (op.load ? 64'sd0 : acc) + addend;
    end
  end

endmodule

// ===== design/r3e_seq.sv =====
// ----------------------------------------------------------------------------
// r3e_seq
// Conversion sequencer: walks the parsed fields through the shared
// multiply-accumulate unit to days, seconds and nanoseconds, with the
// range checks in between.
// ----------------------------------------------------------------------------
module r3e_seq import r3e_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  fields_t            fld,
  input  logic               take,
  input  logic signed [62:0] prod,
  input  logic signed [63:0] acc,
  output mac_op_t            op,
  output res_t               res
);

  fin_state_t         state, state_next;
  step_t              step, step_next;
  fields_t            fq, fq_next;
  logic [6:0]         q100, q100_next;
  logic [4:0]         q400, q400_next;
  logic signed [34:0] secs, secs_next;
  logic               fail, fail_next;

  logic [13:0] y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    step <= step_next;
    fq   <= fq_next;
    q100 <= q100_next;
    q400 <= q400_next;
    secs <= secs_next;
    fail <= fail_next;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    fq_next    = fq;
    q100_next  = q100;
    q400_next  = q400;
    secs_next  = secs;
    fail_next  = fail;

    // Year of a March-based calendar: January and February count with the
    // year before.
    y = fq.year - ((fq.month <= 4'd2) ? 14'd1 : 14'd0);

    op.mul_go   = (state == FS_MUL);
    op.acc_go   = 1'b0;
    op.load     = 1'b0;
    op.shift_hi = 1'b0;
    op.a        = 32'd0;
    op.b        = UNIT_FACTOR;

    case (step)
      ST_Q100: begin
        op.a = {20'b0, y[13:2]};
        op.b = RECIP25;
      end
      ST_Q400: begin
        op.a = {22'b0, y[13:4]};
        op.b = RECIP25;
      end
      ST_YEAR: begin
        op.a    = {18'b0, y};
        op.b    = DAYS_PER_YEAR;
        op.load = 1'b1;
      end
      ST_Y4:   op.a = {20'b0, y[13:2]};
      ST_Y100: op.a = 32'(-$signed({25'b0, q100}));
      ST_Y400: op.a = {27'b0, q400};
      ST_MDAY: begin
        op.a = 32'($signed({23'b0, march_day(fq.month)}) + $signed({27'b0, fq.day})
               - DAYS_BEFORE_EPOCH);
      end
      ST_DAYS: begin
        op.a    = acc[31:0];
        op.b    = SECS_PER_DAY;
        op.load = 1'b1;
      end
      ST_HOUR: begin
        op.a = {27'b0, fq.hour};
        op.b = SECS_PER_HOUR;
      end
      ST_MIN: begin
        op.a = {26'b0, fq.minute};
        op.b = SECS_PER_MIN;
      end
      ST_SEC: op.a = {26'b0, fq.second};
      ST_OFFH: begin
        // A negative offset is added back, a positive one taken off.
        op.a = fq.off_neg ? {27'b0, fq.off_hours} : 32'(-$signed({27'b0, fq.off_hours}));
        op.b = SECS_PER_HOUR;
      end
      ST_OFFM: begin
        op.a = fq.off_neg ? {26'b0, fq.off_minutes}
                          : 32'(-$signed({26'b0, fq.off_minutes}));
        op.b = SECS_PER_MIN;
      end
      ST_FRAC: begin
        op.a    = {2'b0, pow10(FRAC_FULL_DIGITS - fq.frac_cnt)};
        op.b    = fq.frac;
        op.load = 1'b1;
      end
      ST_SLO: begin
        op.a = {15'b0, secs[SPLIT_SHIFT-1:0]};
        op.b = NS_PER_SEC;
      end
      ST_SHI: begin
        op.a        = {{(SPLIT_SHIFT - 3){secs[34]}}, secs[34:SPLIT_SHIFT]};
        op.b        = NS_PER_SEC;
        op.shift_hi = 1'b1;
      end
      default: ;
    endcase

    case (state)
      FS_IDLE: begin
        if (start) begin
          fq_next    = fld;
          fail_next  = fld.bad;
          step_next  = ST_Q100;
          state_next = fld.bad ? FS_DONE : FS_MUL;
        end
      end
      FS_MUL: state_next = FS_ACC;
      FS_ACC: begin
        case (step)
          ST_Q100: q100_next = prod[RECIP_SHIFT +: 7];
          ST_Q400: q400_next = prod[RECIP_SHIFT +: 5];
          default: op.acc_go = 1'b1;
        endcase
        if (step == ST_OFFM || step == ST_FRAC) begin
          state_next = FS_CHECK;
        end else if (step == ST_SHI) begin
          state_next = FS_DONE;
        end else begin
          step_next  = step_t'(4'(step + 4'd1));
          state_next = FS_MUL;
        end
      end
      FS_CHECK: begin
        if (step == ST_OFFM) begin
          if (acc > SECS_LIMIT || acc < -SECS_LIMIT) begin
            fail_next  = 1'b1;
            state_next = FS_DONE;
          end else begin
            secs_next  = acc[34:0];
            step_next  = ST_FRAC;
            state_next = FS_MUL;
          end
        end else begin
          // At the very top second only part of a second still fits.
          if (64'(secs) == SECS_LIMIT && acc > NS_TAIL_LIMIT) begin
            fail_next  = 1'b1;
            state_next = FS_DONE;
          end else begin
            step_next  = ST_SLO;
            state_next = FS_MUL;
          end
        end
      end
      FS_DONE: begin
        if (take) state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase

    res.busy  = (state != FS_IDLE);
    res.valid = (state == FS_DONE);
    res.fail  = fail;
    res.ns    = acc;
  end

endmodule

// ===== design/rfc3339_text_to_epoch_ns_core.sv =====
// ----------------------------------------------------------------------------
// rfc3339_text_to_epoch_ns_core
// Converts RFC3339 timestamp text to signed nanoseconds since the epoch.
// ----------------------------------------------------------------------------
// Input channel: one text character per beat (text_byte), end_of_text marks
// the final character. Output channel: one beat per timestamp with
// parse_status (0 good, 1 malformed or out of range) and epoch_nanoseconds
// (0 on error). Both channels use valid/ready.
// Characters before the final one are taken at one per cycle while the
// sequencer is idle. The final character starts the conversion, which runs
// 16 multiply-accumulate steps, each a multiply state then an accumulate
// state, with range checks after the seconds and after the fraction, through
// one shared 32 x 30 bit multiplier; the input is not ready meanwhile. Text
// that already failed to parse skips the steps.
// The result waits in an output register. While the receiver stalls, the
// next timestamp is still taken and converted; its result then waits in the
// sequencer, and the input stays not ready until the output register is
// free again. Reset clears the parser, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module rfc3339_text_to_epoch_ns_core import r3e_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               parse_status,
  output logic signed [63:0] epoch_nanoseconds
);

  logic               accept;
  logic               take;
  fields_t            fld;
  mac_op_t            op;
  res_t               res;
  logic signed [62:0] prod;
  logic signed [63:0] acc;

  assign in_ready = !res.busy;
  assign accept   = in_valid && in_ready;
  assign take     = res.valid && (!out_valid || out_ready);

  r3e_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .fld         (fld)
  );

  r3e_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (accept && end_of_text),
    .fld   (fld),
    .take  (take),
    .prod  (prod),
    .acc   (acc),
    .op    (op),
    .res   (res)
  );

  r3e_mac u_mac (
    .clk  (clk),
    .op   (op),
    .prod (prod),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      parse_status      <= res.fail;
      epoch_nanoseconds <= res.fail ? 64'sd0 : $signed(res.ns);
    end
  end

endmodule

// ===== design/r3e_checker.sv =====
// ----------------------------------------------------------------------------
// r3e_checker
// Port-level checks of the timestamp converter, bound to the top level.
// ----------------------------------------------------------------------------
module r3e_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         text_byte,
  input logic               end_of_text,
  input logic               out_valid,
  input logic               out_ready,
  input logic               parse_status,
  input logic signed [63:0] epoch_nanoseconds
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(parse_status)
                                && $stable(epoch_nanoseconds))
    else $error("result beat changed while stalled");

  // An error result carries zero nanoseconds.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status |-> epoch_nanoseconds == 64'sd0)
    else $error("error result with nonzero nanoseconds");

  // The final character starts the conversion, which blocks the input.
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_text |=> !in_ready)
    else $error("input ready right after a final character");

  // A good result does not fall below the supported range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !parse_status |-> epoch_nanoseconds >= -64'sd9223372036000000000)
    else $error("good result below the supported range");

endmodule

bind rfc3339_text_to_epoch_ns_core r3e_checker u_r3e_checker (.*);

// ===== tb/rfc3339_epoch_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rfc3339_epoch_checker
// Watches both channels of the RFC3339 converter. It parses every accepted
// text beat with its own copy of the parser state. On the final character it
// queues the expected status and nanoseconds. Each result beat is compared
// with the oldest queued timestamp.
// ----------------------------------------------------------------------------
module rfc3339_epoch_checker
  import r3e_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               parse_status,
  input  logic signed [63:0] epoch_nanoseconds,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_DASH  = 8'h2D;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_DOT   = 8'h2E;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [7:0] ASCII_T     = 8'h54;

  localparam longint MAX_EPOCH_SECS   = 64'sd9223372036;
  localparam longint MAX_TAIL_NS      = 64'sd854775807;
  localparam longint NS_PER_SECOND    = 64'sd1000000000;
  localparam longint EPOCH_DAY_OFFSET = 64'sd719468;

  typedef struct {
    logic               status;
    logic signed [63:0] ns;
  } stamp_result_t;

  stamp_result_t expected_stamps[$];
  stamp_result_t want;

  logic [5:0]  char_pos;
  phase_t      phase;
  logic [13:0] t_year;
  logic [3:0]  t_month;
  logic [4:0]  t_day;
  logic [4:0]  t_hour;
  logic [5:0]  t_minute;
  logic [5:0]  t_second;
  logic [29:0] t_frac;
  logic [3:0]  t_frac_digits;
  logic        z_neg;
  logic [4:0]  z_hours;
  logic [5:0]  z_minutes;
  logic        parse_bad;

  initial fail_count = 0;

  function automatic void clear_parser();
    char_pos = '0;
    phase = PH_FIXED;
    t_year = '0;
    t_month = '0;
    t_day = '0;
    t_hour = '0;
    t_minute = '0;
    t_second = '0;
    t_frac = '0;
    t_frac_digits = '0;
    z_neg = 1'b0;
    z_hours = '0;
    z_minutes = '0;
    parse_bad = 1'b0;
  endfunction

  function automatic bit is_num(logic [7:0] b);
    return (b >= ASCII_0) && (b <= ASCII_9);
  endfunction

  function automatic int days_in_month(int m, int y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Character after the seconds, or one that ends the fraction.
  function automatic void take_separator(logic [7:0] b);
    if (b == ASCII_DOT && phase == PH_AFTER) begin
      phase = PH_FRAC;
    end else if (b == ASCII_PLUS || b == ASCII_DASH) begin
      z_neg = (b == ASCII_DASH);
      phase = PH_OFFSET;
      char_pos = '0;
    end else begin
      phase = PH_TAIL;
    end
  endfunction

  function automatic void take_fixed(logic [7:0] b);
    int d;
    int v;
    d = int'(b) - int'(ASCII_0);
    case (char_pos)
      6'd4, 6'd7:   if (b != ASCII_DASH) parse_bad = 1'b1;
      6'd10:        if (b != ASCII_T) parse_bad = 1'b1;
      6'd13, 6'd16: if (b != ASCII_COLON) parse_bad = 1'b1;
      default: begin
        if (!is_num(b)) begin
          parse_bad = 1'b1;
        end else begin
          case (char_pos)
            6'd0, 6'd1, 6'd2, 6'd3: t_year = 14'(int'(t_year) * 10 + d);
            6'd5: t_month = 4'(d);
            6'd6: begin
              v = int'(t_month) * 10 + d;
              if (t_year < 14'd1970 || v < 1 || v > 12) parse_bad = 1'b1;
              else t_month = 4'(v);
            end
            6'd8: t_day = 5'(d);
            6'd9: begin
              v = int'(t_day) * 10 + d;
              if (v < 1 || v > days_in_month(int'(t_month), int'(t_year))) parse_bad = 1'b1;
              else t_day = 5'(v);
            end
            6'd11: t_hour = 5'(d);
            6'd12: begin
              v = int'(t_hour) * 10 + d;
              if (v > 23) parse_bad = 1'b1; else t_hour = 5'(v);
            end
            6'd14: t_minute = 6'(d);
            6'd15: begin
              v = int'(t_minute) * 10 + d;
              if (v > 59) parse_bad = 1'b1; else t_minute = 6'(v);
            end
            6'd17: t_second = 6'(d);
            default: begin
              // A leap second of 60 is accepted and simply counts.
              v = int'(t_second) * 10 + d;
              if (v > 60) parse_bad = 1'b1; else t_second = 6'(v);
            end
          endcase
        end
      end
    endcase
    if (char_pos >= 6'd18) phase = PH_AFTER;
    else char_pos = char_pos + 6'd1;
  endfunction

  function automatic void take_offset(logic [7:0] b);
    int d;
    int v;
    d = int'(b) - int'(ASCII_0);
    if (char_pos == 6'd2) begin
      if (b != ASCII_COLON) parse_bad = 1'b1;
    end else if (!is_num(b)) begin
      parse_bad = 1'b1;
    end else begin
      case (char_pos)
        6'd0: z_hours = 5'(d);
        6'd1: begin
          v = int'(z_hours) * 10 + d;
          if (v > 23) parse_bad = 1'b1; else z_hours = 5'(v);
        end
        6'd3: z_minutes = 6'(d);
        default: begin
          v = int'(z_minutes) * 10 + d;
          if (v > 59) parse_bad = 1'b1; else z_minutes = 6'(v);
        end
      endcase
    end
    if (char_pos >= 6'd4) phase = PH_TAIL;
    else char_pos = char_pos + 6'd1;
  endfunction

  function automatic void take_char(logic [7:0] b);
    if (!parse_bad) begin
      case (phase)
        PH_FIXED:  take_fixed(b);
        PH_AFTER:  take_separator(b);
        PH_FRAC: begin
          if (is_num(b)) begin
            // Digits beyond the kept precision are dropped.
            if (t_frac_digits < FRACTION_DIGITS) begin
              t_frac = 30'(int'(t_frac) * 10 + int'(b) - int'(ASCII_0));
              t_frac_digits = t_frac_digits + 4'd1;
            end
          end else begin
            take_separator(b);
          end
        end
        PH_OFFSET: take_offset(b);
        default: ;
      endcase
    end
  endfunction

  // Days are counted from a March-based year so February falls last.
  function automatic stamp_result_t epoch_from_fields();
    stamp_result_t r;
    longint y;
    longint mp;
    longint days;
    longint secs;
    longint zone;
    longint frac_ns;
    longint scale;
    r.status = 1'b1;
    r.ns = '0;
    if (parse_bad || phase == PH_FIXED || phase == PH_OFFSET) return r;
    y = longint'(t_year) - ((t_month <= 4'd2) ? 1 : 0);
    mp = (longint'(t_month) + 9) % 12;
    days = 365 * y + y / 4 - y / 100 + y / 400 + (153 * mp + 2) / 5
         + longint'(t_day) - 1 - EPOCH_DAY_OFFSET;
    secs = days * 86400 + longint'(t_hour) * 3600 + longint'(t_minute) * 60
         + longint'(t_second);
    zone = longint'(z_hours) * 3600 + longint'(z_minutes) * 60;
    secs = z_neg ? secs + zone : secs - zone;
    if (secs > MAX_EPOCH_SECS || secs < -MAX_EPOCH_SECS) return r;
    scale = 1;
    repeat (9 - int'(t_frac_digits)) scale = scale * 10;
    frac_ns = longint'(t_frac) * scale;
    if (secs == MAX_EPOCH_SECS && frac_ns > MAX_TAIL_NS) return r;
    r.status = 1'b0;
    r.ns = secs * NS_PER_SECOND + frac_ns;
    return r;
  endfunction

  // The result side is handled before the text side, so a result beat can
  // never be matched with the timestamp that closes on the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      expected_stamps.delete();
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_stamps.size() == 0) begin
          $display("%0t: result beat with none expected: status %0b ns %0d",
                   $time, parse_status, epoch_nanoseconds);
          fail_count = fail_count + 1;
        end else begin
          want = expected_stamps.pop_front();
          if (parse_status !== want.status) begin
            $display("%0t: parse_status expected %0b got %0b",
                     $time, want.status, parse_status);
            fail_count = fail_count + 1;
          end
          if (epoch_nanoseconds !== want.ns) begin
            $display("%0t: epoch_nanoseconds expected %0d got %0d",
                     $time, want.ns, epoch_nanoseconds);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        take_char(text_byte);
        if (end_of_text) begin
          expected_stamps.push_back(epoch_from_fields());
          clear_parser();
        end
      end
      pending <= expected_stamps.size();
    end
  end

endmodule

// ===== tb/tb_rfc3339_text_to_epoch_ns_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rfc3339_text_to_epoch_ns_core
// Sends timestamp text to the RFC3339 converter one beat per character. A
// directed set covers field limits, leap days, leap seconds, offsets, the
// range limit and malformed text. Random timestamps follow, mostly well
// formed with some corrupted, plus raw noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_rfc3339_text_to_epoch_ns_core;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         text_byte = 8'h00;
  logic               end_of_text = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               parse_status;
  logic signed [63:0] epoch_nanoseconds;

  int   fail_count;
  int   pending;
  logic quiet_phase = 1'b0;
  int   stall_left = 0;
  int   chars_sent = 0;
  int   stamps_sent = 0;

  logic [7:0] stamp_chars[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rfc3339_text_to_epoch_ns_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .text_byte         (text_byte),
    .end_of_text       (end_of_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .parse_status      (parse_status),
    .epoch_nanoseconds (epoch_nanoseconds)
  );

  rfc3339_epoch_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .text_byte         (text_byte),
    .end_of_text       (end_of_text),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .parse_status      (parse_status),
    .epoch_nanoseconds (epoch_nanoseconds),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Receiver stalls come in runs of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 99) < 25) begin
      stall_left <= idle_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_char(input logic [7:0] b, input logic last);
    int n;
    if (!quiet_phase && $urandom_range(0, 99) < 30) begin
      n = idle_len();
      in_valid <= 1'b0;
      text_byte <= 8'($urandom);
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent = chars_sent + 1;
  endtask

  task automatic send_stamp();
    for (int i = 0; i < stamp_chars.size(); i++) begin
      send_char(stamp_chars[i], i == stamp_chars.size() - 1);
    end
    stamps_sent = stamps_sent + 1;
  endtask

  task automatic load_text(input string s);
    stamp_chars.delete();
    for (int i = 0; i < s.len(); i++) stamp_chars.push_back(s[i]);
  endtask

  task automatic send_str(input string s);
    load_text(s);
    send_stamp();
  endtask

  // The checker reports its queue depth through a register, so the first
  // sample is taken only after the edge that follows the last beat.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic string two_digits(input bit wild, input int hi);
    return $sformatf("%02d", wild ? $urandom_range(hi + 1, 99) : $urandom_range(0, hi));
  endfunction

  task automatic build_random_stamp();
    int    pick;
    int    yr;
    int    mo;
    int    dy;
    int    n;
    string s;
    pick = $urandom_range(0, 99);
    if (pick < 7) begin
      // Raw noise of 1 to 40 random bytes.
      stamp_chars.delete();
      n = $urandom_range(1, 40);
      repeat (n) stamp_chars.push_back(8'($urandom));
      return;
    end
    if (pick < 13) begin
      // Right at the top of the representable range.
      s = $sformatf("2262-04-11T23:47:%02d.%09d", $urandom_range(14, 18),
                    $urandom_range(854775790, 854775820));
      case ($urandom_range(0, 2))
        0:       s = {s, "Z"};
        1:       s = {s, "+00:01"};
        default: s = {s, "-00:01"};
      endcase
      load_text(s);
      return;
    end
    yr = $urandom_range(1970, 2262);
    if (pick < 23) yr = $urandom_range(2263, 9999);
    else if (pick < 29) yr = $urandom_range(0, 1969);
    mo = ($urandom_range(0, 99) < 4) ? (($urandom_range(0, 1) == 1) ? 0 : $urandom_range(13, 99))
                                    : $urandom_range(1, 12);
    dy = $urandom_range(1, 28);
    n = $urandom_range(0, 99);
    if (n < 15) dy = $urandom_range(29, 31);
    else if (n < 18) dy = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(32, 99);
    if ($urandom_range(0, 9) == 0) begin
      // February 29 in years around the century rules.
      yr = 4 * $urandom_range(493, 565);
      mo = 2;
      dy = 29;
    end
    s = $sformatf("%04d-%02d-%02dT", yr, mo, dy);
    s = {s, two_digits($urandom_range(0, 99) < 4, 23), ":"};
    s = {s, two_digits($urandom_range(0, 99) < 4, 59), ":"};
    if ($urandom_range(0, 99) < 6) s = {s, "60"};
    else s = {s, two_digits($urandom_range(0, 99) < 4, 59)};
    if ($urandom_range(0, 99) < 45) begin
      s = {s, "."};
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
      repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    n = $urandom_range(0, 99);
    if (n < 30) s = {s, "Z"};
    else if (n < 38) s = {s, "z"};
    else if (n < 75) begin
      s = {s, ($urandom_range(0, 1) == 1) ? "-" : "+"};
      s = {s, two_digits($urandom_range(0, 99) < 5, 23), ":"};
      s = {s, two_digits($urandom_range(0, 99) < 5, 59)};
    end
    load_text(s);
    if (n >= 88) stamp_chars.push_back(8'($urandom));
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 6)) stamp_chars.push_back(8'($urandom));
    end
    n = $urandom_range(0, 99);
    if (n < 8) begin
      stamp_chars[$urandom_range(0, stamp_chars.size() - 1)] = 8'($urandom);
    end else if (n < 13) begin
      repeat ($urandom_range(1, stamp_chars.size() - 1)) void'(stamp_chars.pop_back());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_str("1970-01-01T00:00:00Z");
    send_str("1970-01-01T00:00:00");
    send_str("2262-04-11T23:47:16.854775807Z");
    send_str("2262-04-11T23:47:16.854775808Z");
    send_str("2262-04-11T23:47:17z");
    send_str("9999-12-31T23:59:60.999999999+23:59");
    send_str("1970-01-01T00:00:00.000000001+23:59");
    send_str("1970-01-01T00:00:00-23:59");
    send_str("2000-02-29T23:59:60.123456789123-00:00");
    send_str("1969-12-31T23:59:59Z");
    send_str("2100-02-29T00:00:00Z");
    send_str("2023-13-01T00:00:00Z");
    send_str("2023-04-00T00:00:00Z");
    send_str("2023-04-31T00:00:00Z");
    send_str("2023-06-15T24:00:00Z");
    send_str("2023-06-15T23:60:00Z");
    send_str("2023-06-15T23:59:61Z");
    send_str("2023-06-15T8:09:10Z");
    send_str("2023-06-15T08:09:10.");
    send_str("2023-06-15T08:09:10.5.3+01:00");
    send_str("2023-06-15T08:09:10.25+05:30 trailing");
    send_str("2023-06-15T08:09:10x+01:00");
    send_str("2023-06-15T08:09:10+05");
    send_str("2023-06-15T08:09:10+24:00");
    send_str("2023-06-15T08:09:10-05:60");
    send_str("2023-06-15T08:09:10+0530");
    send_str("2023/06/15T08:09:10Z");
    send_str("2023-06-15 08:09:10Z");
    send_str("2023-06");
    send_str("7");
    // A NUL right after the seconds also means UTC.
    load_text("2023-06-15T08:09:10");
    stamp_chars.push_back(8'h00);
    stamp_chars.push_back(8'hFF);
    send_stamp();

    stamps_sent = 0;
    while (chars_sent < 900) begin
      quiet_phase <= ($urandom_range(0, 9) == 0);
      build_random_stamp();
      send_stamp();
      if (stamps_sent == 1 || $urandom_range(0, 14) == 0) wait_drained();
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("rfc3339_text_to_epoch_ns_core regression: pass");
    end else begin
      $display("rfc3339_text_to_epoch_ns_core regression: fail");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("rfc3339_text_to_epoch_ns_core regression: fail");
    $finish;
  end

endmodule

// ===== rfc3339_text_to_epoch_ns_core.f =====
design/r3e_pkg.sv
design/r3e_parser.sv
design/r3e_mac.sv
design/r3e_seq.sv
design/rfc3339_text_to_epoch_ns_core.sv
design/r3e_checker.sv
tb/rfc3339_epoch_checker.sv
tb/tb_rfc3339_text_to_epoch_ns_core.sv
